[rtl/mos_gate_capacitance_meyer_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Meyer gate capacitance block
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MOS_GATE_CAPACITANCE_MEYER_TOP_ASSERT_SVH
`define MOS_GATE_CAPACITANCE_MEYER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MGC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MGC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/mgc_pkg.sv]
// ----------------------------------------------------------------------------
// mgc_pkg
// Widths, register codes, region codes and channel payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package mgc_pkg;

	localparam int VOLT_W    = 24;
	localparam int PHI_W     = 23;
	localparam int COX_W     = 24;
	localparam int CFG_IDX_W = 4;
	// Remainder width of the linear-region dividers: 3 * (2 * Vsat - Vds)^2 fits here.
	localparam int LIN_W     = 52;

	localparam logic [PHI_W-1:0] PHI_RESET = 23'd39322;
	localparam logic [COX_W-1:0] COX_RESET = 24'd65536;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_PHI = 4'd0;
	localparam cfg_idx_t CFG_COX = 4'd1;

	typedef enum logic [2:0] {
		RG_CUTOFF = 3'd0,
		RG_WEAK   = 3'd1,
		RG_DEPL   = 3'd2,
		RG_SAT    = 3'd3,
		RG_LIN    = 3'd4
	} region_t;

	typedef struct packed {
		logic signed [VOLT_W-1:0] v_gate_source;
		logic signed [VOLT_W-1:0] v_gate_drain;
		logic signed [VOLT_W-1:0] v_threshold;
		logic signed [VOLT_W-1:0] v_drain_sat;
	} bias_t;

	typedef struct packed {
		logic [COX_W-1:0] cap_gs;
		logic [COX_W-1:0] cap_gd;
		logic [COX_W-1:0] cap_gb;
		region_t          region;
	} caps_t;

endpackage

`default_nettype wire

[rtl/mgc_ifs.sv]
// ----------------------------------------------------------------------------
// mgc channel interfaces
// Bias point input stream, capacitance result stream and register write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface mgc_bias_if;
	logic          valid;
	logic          ready;
	mgc_pkg::bias_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mgc_caps_if;
	logic          valid;
	logic          ready;
	mgc_pkg::caps_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mgc_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [mgc_pkg::CFG_IDX_W-1:0] index;
	logic [mgc_pkg::COX_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/mgc_muldiv.sv]
// ----------------------------------------------------------------------------
// mgc_muldiv
// Pipelined floor(cox * n / d) for n < d, one bit of cox per stage, MSB first; cox when sat_in is set.
// ----------------------------------------------------------------------------
`default_nettype none

module mgc_muldiv
	import mgc_pkg::*;
#(
	parameter int W = LIN_W
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [COX_W-1:0] cox,
	input  wire logic [W-1:0]     n_in,
	input  wire logic [W-1:0]     d_in,
	input  wire logic             sat_in,
	output logic      [COX_W-1:0] q_out
);

	localparam int STG = COX_W;

	logic [W-1:0]     rem_s [1:STG];
	logic [W-1:0]     num_s [1:STG];
	logic [W-1:0]     den_s [1:STG];
	logic [COX_W-1:0] quo_s [1:STG];
	logic             sat_s [1:STG];

	// Invariant: prefix(cox) * n / d == quo + rem / d with rem < d. Appending one
	// bit doubles the value and adds n / d, so the new remainder stays below 3d.
	for (genvar k = 1; k <= STG; k++) begin : g_step
		logic [W-1:0]     r_p, n_p, d_p;
		logic [COX_W-1:0] q_p;
		logic             s_p;
		logic [W+1:0]     t, t1, t2;
		logic [COX_W:0]   qn;
		logic [W-1:0]     rn;

		if (k == 1) begin : g_first
			assign r_p = '0;
			assign q_p = '0;
			assign n_p = n_in;
			assign d_p = d_in;
			assign s_p = sat_in;
		end else begin : g_rest
			assign r_p = rem_s[k-1];
			assign q_p = quo_s[k-1];
			assign n_p = num_s[k-1];
			assign d_p = den_s[k-1];
			assign s_p = sat_s[k-1];
		end

		always_comb begin
			t  = {1'b0, r_p, 1'b0} + (cox[STG-k] ? {2'b00, n_p} : '0);
			t1 = t - {2'b00, d_p};
			t2 = t - {1'b0, d_p, 1'b0};
			if (t >= {1'b0, d_p, 1'b0}) begin
				rn = t2[W-1:0];
				qn = {q_p, 1'b0} + (COX_W+1)'(2);
			end else if (t >= {2'b00, d_p}) begin
				rn = t1[W-1:0];
				qn = {q_p, 1'b0} + (COX_W+1)'(1);
			end else begin
				rn = t[W-1:0];
				qn = {q_p, 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rn;
				quo_s[k] <= qn[COX_W-1:0];
				num_s[k] <= n_p;
				den_s[k] <= d_p;
				sat_s[k] <= s_p;
			end
		end
	end

	assign q_out = sat_s[STG] ? cox : quo_s[STG];

endmodule

`default_nettype wire

[rtl/mos_gate_capacitance_meyer_top.sv]
// ----------------------------------------------------------------------------
// mos_gate_capacitance_meyer_top
// Meyer gate capacitance evaluator: region select and saturated Cgs, Cgd, Cgb.
// ----------------------------------------------------------------------------
// The block takes one bias point per clock and returns one result per clock,
// in the order of the transactions that carried them. Five front-end stages form
// the overdrive, pick the region, square the drain terms and settle the
// saturating cases; three multiply-divide lanes then spend one stage per bit
// of oxide_cap, 24 stages, behind the front end. When the result side
// stalls, the whole pipeline holds. Register writes take effect at once and
// belong only in idle periods.
`default_nettype none

module mos_gate_capacitance_meyer_top
	import mgc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	mgc_bias_if.sink    bias,
	mgc_caps_if.source  caps,
	mgc_cfg_if.sink     cfg
);

	localparam int LANE_STAGES = COX_W;

	logic [PHI_W-1:0] phi_q;
	logic [COX_W-1:0] cox_q;
	logic [PHI_W-1:0] phi_eff;
	logic             en;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phi_q <= PHI_RESET;
			cox_q <= COX_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_PHI) phi_q <= cfg.data[PHI_W-1:0];
			if (cfg.index == CFG_COX) cox_q <= cfg.data;
		end
	end

	// A zero surface potential acts as one LSB.
	assign phi_eff = (phi_q == '0) ? PHI_W'(1) : phi_q;

	// Valid bits.
	logic                   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [LANE_STAGES-1:0] lane_vld_s;

	assign en         = !lane_vld_s[LANE_STAGES-1] || caps.ready;
	assign bias.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			v_s5       <= 1'b0;
			lane_vld_s <= '0;
		end else if (en) begin
			v_s1       <= bias.valid;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			v_s4       <= v_s3;
			v_s5       <= v_s4;
			lane_vld_s <= {lane_vld_s[LANE_STAGES-2:0], v_s5};
		end
	end

	// Stage 1: overdrive and drain-source voltage.
	logic signed [24:0] utst_s1, uds_s1;
	logic signed [23:0] vsat_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			utst_s1 <= {bias.data.v_gate_source[23], bias.data.v_gate_source}
				- {bias.data.v_threshold[23], bias.data.v_threshold};
			uds_s1  <= {bias.data.v_gate_source[23], bias.data.v_gate_source}
				- {bias.data.v_gate_drain[23], bias.data.v_gate_drain};
			vsat_s1 <= bias.data.v_drain_sat;
		end
	end

	// Stage 2: region decision and the divider operands of the low regions.
	logic signed [25:0] utst_x, utst2_x, neg_phi_x;
	logic signed [24:0] vsat_x;
	logic [24:0]        neg_utst;
	logic [26:0]        depn_x;
	region_t            rg_x;
	logic               depl_x;

	region_t            rg_s2;
	logic [PHI_W-1:0]   gbn_s2;
	logic               gbsat_s2;
	logic [24:0]        depn_s2, dep3_s2;
	logic signed [25:0] d1_s2;
	logic signed [26:0] d2_s2;
	logic signed [23:0] vsat_s2;

	always_comb begin
		utst_x    = {utst_s1[24], utst_s1};
		utst2_x   = {utst_s1, 1'b0};
		neg_phi_x = $signed(26'd0 - {3'b000, phi_eff});
		vsat_x    = {vsat_s1[23], vsat_s1};
		neg_utst  = 25'd0 - utst_s1;
		depn_x    = {utst_s1, 2'b00} + {3'b000, phi_eff, 1'b0};
		depl_x    = utst_s1[24] || (utst_s1 == '0);
		if (utst_x <= neg_phi_x)       rg_x = RG_CUTOFF;
		else if (utst2_x <= neg_phi_x) rg_x = RG_WEAK;
		else if (depl_x)               rg_x = RG_DEPL;
		else if (vsat_x <= uds_s1)     rg_x = RG_SAT;
		else                           rg_x = RG_LIN;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rg_s2    <= rg_x;
			gbsat_s2 <= (rg_x == RG_CUTOFF);
			// Here -Utst lies below phi, so it fits the potential's width.
			gbn_s2   <= (rg_x == RG_WEAK || rg_x == RG_DEPL) ? neg_utst[PHI_W-1:0] : '0;
			depn_s2  <= depn_x[24:0];
			dep3_s2  <= {2'b00, phi_eff} + {1'b0, phi_eff, 1'b0};
			d1_s2    <= {vsat_s1[23], vsat_s1[23], vsat_s1}
				- {uds_s1[24], uds_s1};
			d2_s2    <= {vsat_s1[23], vsat_s1[23], vsat_s1, 1'b0}
				- {uds_s1[24], uds_s1[24], uds_s1};
			vsat_s2  <= vsat_s1;
		end
	end

	// Stage 3: squares.
	logic signed [51:0] p1_x;
	logic signed [53:0] p2_x;
	logic signed [47:0] pv_x;

	region_t          rg_s3;
	logic [PHI_W-1:0] gbn_s3;
	logic             gbsat_s3;
	logic [24:0]      depn_s3, dep3_s3;
	logic [49:0]      s1_s3;
	logic [50:0]      s2_s3;
	logic [46:0]      sv_s3;

	always_comb begin
		p1_x = d1_s2 * d1_s2;
		p2_x = d2_s2 * d2_s2;
		pv_x = vsat_s2 * vsat_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rg_s3    <= rg_s2;
			gbn_s3   <= gbn_s2;
			gbsat_s3 <= gbsat_s2;
			depn_s3  <= depn_s2;
			dep3_s3  <= dep3_s2;
			s1_s3    <= p1_x[49:0];
			s2_s3    <= p2_x[50:0];
			sv_s3    <= pv_x[46:0];
		end
	end

	// Stage 4: numerators of the linear-region fractions.
	region_t            rg_s4;
	logic [PHI_W-1:0]   gbn_s4;
	logic               gbsat_s4;
	logic [24:0]        depn_s4, dep3_s4;
	logic signed [51:0] ngs_s4, ngd_s4;
	logic [50:0]        den_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			rg_s4    <= rg_s3;
			gbn_s4   <= gbn_s3;
			gbsat_s4 <= gbsat_s3;
			depn_s4  <= depn_s3;
			dep3_s4  <= dep3_s3;
			ngs_s4   <= {1'b0, s2_s3} - {2'b00, s1_s3};
			ngd_s4   <= {1'b0, s2_s3} - {5'b00000, sv_s3};
			den_s4   <= s2_s3;
		end
	end

	// Stage 5: saturating cases and final lane operands.
	logic [LIN_W-1:0] three_d, two_gs, two_gd;
	logic             pos_gs, pos_gd, zero_gs, zero_gd, full_gs, full_gd;
	logic [LIN_W-1:0] gsn_x, gsd_x, gdn_x, gdd_x;
	logic             gssat_x, gdsat_x;

	region_t          rg_s5;
	logic [PHI_W-1:0] gbn_s5;
	logic             gbsat_s5;
	logic [LIN_W-1:0] gsn_s5, gsd_s5, gdn_s5, gdd_s5;
	logic             gssat_s5, gdsat_s5;

	always_comb begin
		three_d = {1'b0, den_s4} + {den_s4, 1'b0};
		two_gs  = {ngs_s4[50:0], 1'b0};
		two_gd  = {ngd_s4[50:0], 1'b0};
		pos_gs  = !ngs_s4[51] && (ngs_s4 != '0);
		pos_gd  = !ngd_s4[51] && (ngd_s4 != '0);
		// A zero divisor or a fraction at or below zero gives zero.
		zero_gs = (den_s4 == '0) || !pos_gs;
		zero_gd = (den_s4 == '0) || !pos_gd;
		full_gs = !zero_gs && (two_gs >= three_d);
		full_gd = !zero_gd && (two_gd >= three_d);
		gssat_x = 1'b0;
		gsn_x   = '0;
		gsd_x   = LIN_W'(1);
		gdsat_x = 1'b0;
		gdn_x   = '0;
		gdd_x   = LIN_W'(1);
		case (rg_s4)
			RG_DEPL: begin
				gsn_x = LIN_W'(depn_s4);
				gsd_x = LIN_W'(dep3_s4);
			end
			RG_SAT: begin
				gsn_x = LIN_W'(2);
				gsd_x = LIN_W'(3);
			end
			RG_LIN: begin
				gssat_x = full_gs;
				gdsat_x = full_gd;
				if (!zero_gs && !full_gs) begin
					gsn_x = two_gs;
					gsd_x = three_d;
				end
				if (!zero_gd && !full_gd) begin
					gdn_x = two_gd;
					gdd_x = three_d;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rg_s5    <= rg_s4;
			gbn_s5   <= gbn_s4;
			gbsat_s5 <= gbsat_s4;
			gssat_s5 <= gssat_x;
			gsn_s5   <= gsn_x;
			gsd_s5   <= gsd_x;
			gdsat_s5 <= gdsat_x;
			gdn_s5   <= gdn_x;
			gdd_s5   <= gdd_x;
		end
	end

	// Multiply-divide lanes and the region code that travels beside them.
	region_t    lane_rg_s [LANE_STAGES];
	logic [COX_W-1:0] cgs, cgd, cgb;

	always_ff @(posedge clk) begin
		if (en) begin
			lane_rg_s[0] <= rg_s5;
			for (int k = 1; k < LANE_STAGES; k++) lane_rg_s[k] <= lane_rg_s[k-1];
		end
	end

	mgc_muldiv #(.W(LIN_W)) u_gs (
		.clk(clk), .en(en), .cox(cox_q),
		.n_in(gsn_s5), .d_in(gsd_s5), .sat_in(gssat_s5), .q_out(cgs)
	);

	mgc_muldiv #(.W(LIN_W)) u_gd (
		.clk(clk), .en(en), .cox(cox_q),
		.n_in(gdn_s5), .d_in(gdd_s5), .sat_in(gdsat_s5), .q_out(cgd)
	);

	mgc_muldiv #(.W(PHI_W)) u_gb (
		.clk(clk), .en(en), .cox(cox_q),
		.n_in(gbn_s5), .d_in(phi_eff), .sat_in(gbsat_s5), .q_out(cgb)
	);

	assign caps.valid       = lane_vld_s[LANE_STAGES-1];
	assign caps.data.cap_gs = cgs;
	assign caps.data.cap_gd = cgd;
	assign caps.data.cap_gb = cgb;
	assign caps.data.region = lane_rg_s[LANE_STAGES-1];

endmodule

`default_nettype wire

[rtl/mgc_checker.sv]
// ----------------------------------------------------------------------------
// mgc_checker
// Port-level checks of the Meyer capacitance block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mos_gate_capacitance_meyer_top_assert.svh"

module mgc_checker
	import mgc_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             caps_valid,
	input wire logic             caps_ready,
	input wire caps_t            caps_data,
	input wire logic             cfg_valid,
	input wire logic             cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [COX_W-1:0] cfg_data
);

	logic [COX_W-1:0] cox_q;

	// Shadow of the oxide capacitance register, the ceiling of every result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cox_q <= COX_RESET;
		end else if (cfg_valid && cfg_ready && cfg_index == CFG_COX) begin
			cox_q <= cfg_data;
		end
	end

	`MGC_ASSERT_SAME(a_cap_ceiling, caps_valid, caps_data.cap_gs <= cox_q && caps_data.cap_gd <= cox_q && caps_data.cap_gb <= cox_q, "capacitance above oxide capacitance")
	`MGC_ASSERT_SAME(a_cutoff, caps_valid && caps_data.region == RG_CUTOFF, caps_data.cap_gs == '0 && caps_data.cap_gd == '0 && caps_data.cap_gb == cox_q, "cutoff result wrong")
	`MGC_ASSERT_SAME(a_no_gd_low, caps_valid && (caps_data.region == RG_WEAK || caps_data.region == RG_DEPL || caps_data.region == RG_SAT), caps_data.cap_gd == '0, "gate-drain capacitance outside linear region")
	`MGC_ASSERT_NEXT(a_hold, caps_valid && !caps_ready, caps_valid && $stable(caps_data), "stalled result changed")

endmodule

bind mos_gate_capacitance_meyer_top mgc_checker u_mgc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.caps_valid(caps.valid),
	.caps_ready(caps.ready),
	.caps_data(caps.data),
	.cfg_valid(cfg.valid),
	.cfg_ready(cfg.ready),
	.cfg_index(cfg.index),
	.cfg_data(cfg.data)
);

`default_nettype wire
